// ===== design/tcgr_pkg.sv =====
package tcgr_pkg;

  localparam int GLYPH_COUNT_DEF = 128;
  localparam int GLYPH_ROWS_DEF  = 16;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 768;

  // cells are always one byte wide
  localparam int GLYPH_COLS = 8;

  localparam logic [7:0]  TOP_CODE     = 8'h7F;
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [31:0] FORE_RESET   = 32'h00FF_FFFF;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_PUT_CHAR   = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_LOAD_GLYPH = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE        = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_FORE_COLOR    = 3'd3,
    REG_BACK_COLOR    = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DRAW = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [6:0] cursor_col;
    logic [7:0] cursor_row;
    logic [3:0] glyph_row_index;
    logic [7:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  write_mask;
    logic [7:0]  fore_mask;
    logic [31:0] fore_color;
    logic [31:0] back_color;
    logic        last;
  } out_item_t;

endpackage

// ===== design/text_console_glyph_renderer_core.sv =====
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_data  (operation, char, cursor, glyph row)
// out     | out | out_valid / out_ready | out_data (one cell row per transaction)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Set cursor, glyph load, newline and disabled put-char are taken without leaving the idle state.
// A drawn character holds off input until all GLYPH_ROWS rows of its glyph have been read (one glyph
// memory read per row on the single read port).
// The last row may still wait at the output while the next transaction is taken.
// Output stalls freeze the read stage (read enable drops, read data holds).
// rst is synchronous; the glyph store has no reset and needs no clearing pass.
module text_console_glyph_renderer_core #(
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
  parameter int MAX_WIDTH   = tcgr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = tcgr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tcgr_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tcgr_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);
  import tcgr_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROW_W = $clog2(GLYPH_ROWS);

  // configuration
  logic        enable;
  logic [10:0] screen_width;
  logic [9:0]  screen_height;
  logic [31:0] fore_color_reg;
  logic [31:0] back_color_reg;

  logic [10:0] w_eff;
  logic [9:0]  h_eff;

  // control
  state_t           state, state_next;
  logic [6:0]       col, col_next;
  logic [7:0]       row, row_next;
  logic [ROW_W-1:0] cnt, cnt_next;

  // cell being drawn
  logic [AW-1:0] base_addr;
  logic [9:0]    cell_x;
  logic [11:0]   cell_y0;
  logic [7:0]    cell_xmask;
  logic          cell_bg;

  // read stage
  logic          s1_valid;
  logic [9:0]    s1_x;
  logic [11:0]   s1_y;
  logic [7:0]    s1_wm;
  logic          s1_bg;
  logic          s1_last;

  logic [7:0]    glyph_mem [DEPTH];
  logic [7:0]    mem_q;

  op_t           op;
  logic          in_acc, adv, issue, draw_start, glyph_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    col_inc;
  logic          wrap;
  logic [7:0]    row_inc;
  logic [9:0]    col_x;
  logic [7:0]    xmask_c;
  logic [11:0]   row_y;
  logic [7:0]    row_wm;
  logic          row_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      screen_width   <= '0;
      screen_height  <= '0;
      fore_color_reg <= FORE_RESET;
      back_color_reg <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:        enable         <= cfg_data[0];
        REG_SCREEN_WIDTH:  screen_width   <= cfg_data[10:0];
        REG_SCREEN_HEIGHT: screen_height  <= cfg_data[9:0];
        REG_FORE_COLOR:    fore_color_reg <= cfg_data;
        REG_BACK_COLOR:    back_color_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (screen_width < 11'(MAX_WIDTH)) ? screen_width : 11'(MAX_WIDTH);
  assign h_eff = (screen_height < 10'(MAX_HEIGHT)) ? screen_height : 10'(MAX_HEIGHT);

  assign op         = op_t'(in_data.operation);
  assign in_ready   = (state == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign adv        = !s1_valid || out_ready;
  assign issue      = (state == ST_DRAW) && adv;
  assign draw_start = in_acc && (op == OP_PUT_CHAR) && enable
                      && (in_data.char_code != NEWLINE_CODE);

  assign glyph_we = in_acc && (op == OP_LOAD_GLYPH)
                    && ({1'b0, in_data.char_code} < 9'(GLYPH_COUNT))
                    && ({1'b0, in_data.glyph_row_index} < 5'(GLYPH_ROWS));
  assign wr_addr  = AW'(32'(in_data.char_code) * GLYPH_ROWS
                        + 32'(in_data.glyph_row_index));

  // cursor advance
  assign col_inc = {1'b0, col} + 8'd1;
  assign wrap    = (11'(32'(col_inc) * GLYPH_COLS) >= w_eff) || (col == 7'h7F);
  assign row_inc = (row == 8'hFF) ? row : row + 8'd1;
  assign col_x   = 10'(32'(col) * GLYPH_COLS);

  always_comb begin
    for (int k = 0; k < GLYPH_COLS; k++) begin
      xmask_c[GLYPH_COLS-1-k] = ({1'b0, col_x} + 11'(k)) < w_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_SET_CURSOR: begin
              col_next = in_data.cursor_col;
              row_next = in_data.cursor_row;
            end
            OP_PUT_CHAR: begin
              if (enable) begin
                if (in_data.char_code == NEWLINE_CODE || wrap) begin
                  col_next = '0;
                  row_next = row_inc;
                end else begin
                  col_next = col_inc[6:0];
                end
                if (in_data.char_code != NEWLINE_CODE) begin
                  state_next = ST_DRAW;
                  cnt_next   = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAW: begin
        if (issue) begin
          cnt_next = cnt + ROW_W'(1);
          if (row_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // cell context, captured when a draw starts
  always_ff @(posedge clk) begin
    if (draw_start) begin
      cell_x     <= col_x;
      cell_y0    <= 12'(32'(row) * GLYPH_ROWS);
      cell_xmask <= xmask_c;
      cell_bg    <= in_data.char_code > TOP_CODE;
      base_addr  <= (in_data.char_code > TOP_CODE) ? '0
                    : AW'(32'(in_data.char_code) * GLYPH_ROWS);
    end
  end

  assign rd_addr  = base_addr + AW'(cnt);
  assign row_y    = cell_y0 + 12'(cnt);
  assign row_wm   = (row_y < {2'b00, h_eff}) ? cell_xmask : 8'h00;
  assign row_last = (cnt == ROW_W'(GLYPH_ROWS - 1));

  always_ff @(posedge clk) begin
    if (glyph_we) glyph_mem[wr_addr] <= in_data.glyph_bits;
    if (issue)    mem_q <= glyph_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_x    <= cell_x;
      s1_y    <= row_y;
      s1_wm   <= row_wm;
      s1_bg   <= cell_bg;
      s1_last <= row_last;
    end
  end

  assign out_valid           = s1_valid;
  assign out_data.pixel_x    = s1_x;
  assign out_data.pixel_y    = s1_y;
  assign out_data.write_mask = s1_wm;
  assign out_data.fore_mask  = s1_bg ? 8'h00 : (mem_q & s1_wm);
  assign out_data.fore_color = fore_color_reg;
  assign out_data.back_color = back_color_reg;
  assign out_data.last       = s1_last;

endmodule

// ===== design/tcgr_checker.sv =====
module tcgr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input tcgr_pkg::out_item_t            out_data
);
  import tcgr_pkg::*;

  // a stalled row keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // no new transaction is taken while a cell is mid-draw
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input taken during a cell draw");

  // rows of one cell come back to back, one line apart, same column
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=>
      out_valid && (out_data.pixel_y == $past(out_data.pixel_y) + 12'd1)
      && (out_data.pixel_x == $past(out_data.pixel_x)))
    else $error("cell rows out of sequence");

  a_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.fore_mask & ~out_data.write_mask) == 8'h00))
    else $error("foreground pixel outside the screen");

endmodule

bind text_console_glyph_renderer_core tcgr_checker u_tcgr_checker (.*);

// ===== dv/tb.sv =====
module tb;
  import tcgr_pkg::*;

  localparam int ROWS = GLYPH_ROWS_DEF;
  localparam int CHARS = GLYPH_COUNT_DEF;
  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int MAX_H = MAX_HEIGHT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  text_console_glyph_renderer_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // console state as the block should hold it
  logic [6:0] cur_col = '0;
  logic [7:0] cur_row = '0;
  logic con_enable = 1'b0;
  logic [10:0] con_width = '0;
  logic [9:0] con_height = '0;
  logic [31:0] con_fore = FORE_RESET;
  logic [31:0] con_back = '0;
  logic [7:0] glyph_copy [CHARS*ROWS];
  bit glyph_set [CHARS*ROWS];
  bit code_ready [CHARS];
  int ready_codes[$];

  out_item_t cell_rows_q[$];
  out_item_t want_row;
  bit calm = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_rows = 0;
  int n_cfg = 0;
  int n_cells = 0;

  task automatic advance_line();
    cur_col = '0;
    if (cur_row != 8'd255) cur_row = cur_row + 8'd1;
  endtask

  task automatic render_item(input in_item_t it);
    int eff_w, eff_h, x, y, idx;
    logic [7:0] xmask, wm, bits;
    out_item_t row_exp;
    bit full;
    case (it.operation)
      OP_SET_CURSOR: begin
        cur_col = it.cursor_col;
        cur_row = it.cursor_row;
      end
      OP_LOAD_GLYPH: begin
        if (it.char_code < CHARS && it.glyph_row_index < ROWS) begin
          idx = int'(it.char_code) * ROWS + int'(it.glyph_row_index);
          glyph_copy[idx] = it.glyph_bits;
          glyph_set[idx] = 1'b1;
          full = 1'b1;
          for (int r = 0; r < ROWS; r++) full &= glyph_set[int'(it.char_code) * ROWS + r];
          if (full && !code_ready[it.char_code]) begin
            code_ready[it.char_code] = 1'b1;
            ready_codes.push_back(int'(it.char_code));
          end
        end
      end
      OP_PUT_CHAR: begin
        if (con_enable) begin
          if (it.char_code == NEWLINE_CODE) begin
            advance_line();
          end else begin
            eff_w = (con_width < MAX_W) ? int'(con_width) : MAX_W;
            eff_h = (con_height < MAX_H) ? int'(con_height) : MAX_H;
            x = int'(cur_col) * GLYPH_COLS;
            xmask = '0;
            for (int k = 0; k < 8; k++) if (x + k < eff_w) xmask[7-k] = 1'b1;
            for (int r = 0; r < ROWS; r++) begin
              y = int'(cur_row) * ROWS + r;
              wm = (y < eff_h) ? xmask : 8'h00;
              bits = (it.char_code <= TOP_CODE) ? glyph_copy[int'(it.char_code) * ROWS + r]
                                                 : 8'h00;
              row_exp.pixel_x = 10'(x);
              row_exp.pixel_y = 12'(y);
              row_exp.write_mask = wm;
              row_exp.fore_mask = bits & wm;
              row_exp.fore_color = con_fore;
              row_exp.back_color = con_back;
              row_exp.last = (r == ROWS - 1);
              cell_rows_q.push_back(row_exp);
            end
            n_cells++;
            if ((int'(cur_col) + 1) * GLYPH_COLS >= eff_w || int'(cur_col) + 1 > 127)
              advance_line();
            else
              cur_col = cur_col + 7'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t rand_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk_put(input logic [7:0] code);
    in_item_t it;
    it = rand_fields();
    it.operation = OP_PUT_CHAR;
    it.char_code = code;
    return it;
  endfunction

  function automatic in_item_t mk_cursor(input logic [6:0] col, input logic [7:0] row);
    in_item_t it;
    it = rand_fields();
    it.operation = OP_SET_CURSOR;
    it.cursor_col = col;
    it.cursor_row = row;
    return it;
  endfunction

  function automatic in_item_t mk_load(input logic [7:0] code, input logic [3:0] row,
                                       input logic [7:0] bits);
    in_item_t it;
    it = rand_fields();
    it.operation = OP_LOAD_GLYPH;
    it.char_code = code;
    it.glyph_row_index = row;
    it.glyph_bits = bits;
    return it;
  endfunction

  // drawn codes up to TOP_CODE are always fully loaded unless the console is off
  function automatic in_item_t rand_item();
    in_item_t it;
    int p, k;
    it = rand_fields();
    p = $urandom_range(0, 99);
    if (p < 45) begin
      it.operation = OP_PUT_CHAR;
      k = $urandom_range(0, 99);
      if (k < 10) it.char_code = NEWLINE_CODE;
      else if (k < 25) it.char_code = 8'($urandom_range(128, 255));
      else if (con_enable)
        it.char_code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
    end else if (p < 62) begin
      it.operation = OP_SET_CURSOR;
      if ($urandom_range(0, 1)) it.cursor_row = 8'($urandom_range(0, 47));
    end else if (p < 85) begin
      it.operation = OP_LOAD_GLYPH;
      if ($urandom_range(0, 99) < 70)
        it.char_code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
      else
        it.char_code = 8'($urandom_range(0, CHARS - 1));
    end else if (p < 93) begin
      it.operation = OP_LOAD_GLYPH;
      it.char_code = 8'($urandom_range(CHARS, 255));
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    render_item(it);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cell_rows_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:        con_enable = val[0];
      REG_SCREEN_WIDTH:  con_width = val[10:0];
      REG_SCREEN_HEIGHT: con_height = val[9:0];
      REG_FORE_COLOR:    con_fore = val;
      REG_BACK_COLOR:    con_back = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic apply_config(input logic en, input int w, input int h,
                              input logic [31:0] fg, input logic [31:0] bg);
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_SCREEN_WIDTH, 32'(w));
    write_reg(REG_SCREEN_HEIGHT, 32'(h));
    write_reg(REG_FORE_COLOR, fg);
    write_reg(REG_BACK_COLOR, bg);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_screen_setup();
    case ($urandom_range(0, 4))
      0: apply_config(1'b1, MAX_W, MAX_H, $urandom, $urandom);
      1: apply_config(1'b1, $urandom_range(0, MAX_W), $urandom_range(0, MAX_H),
                      $urandom, $urandom);
      2: apply_config(1'b0, MAX_W, MAX_H, $urandom, $urandom);
      3: apply_config(1'b1, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
      default: apply_config(1'b1, $urandom_range(8, 200), $urandom_range(16, 300),
                            32'hFFFF_FFFF, 32'h0000_0000);
    endcase
  endtask

  // console comes out of reset disabled: put-char and newline do nothing
  task automatic test_disabled_console();
    send_item(mk_put(8'h41));
    send_item(mk_put(NEWLINE_CODE));
    send_item(mk_put(8'hFF));
    send_item(mk_cursor(7'd5, 8'd3));
    send_item(mk_put(8'h00));
    wait_drained();
  endtask

  task automatic test_glyph_loading();
    logic [7:0] codes [6];
    logic [7:0] bits;
    codes = '{8'h00, 8'h7F, 8'h55, 8'h2A, 8'h41, 8'h3C};
    foreach (codes[i]) begin
      for (int r = 0; r < ROWS; r++) begin
        if (codes[i] == TOP_CODE) bits = 8'hFF;
        else if (codes[i] == 8'h00) bits = 8'h00;
        else bits = 8'($urandom);
        send_item(mk_load(codes[i], 4'(r), bits));
      end
    end
    // out-of-range codes are dropped
    send_item(mk_load(8'h80, 4'd0, 8'hFF));
    send_item(mk_load(8'hFF, 4'd15, 8'hA5));
    wait_drained();
  endtask

  task automatic test_drawing_edges();
    in_item_t odd;
    // colors stay at reset values here
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_SCREEN_WIDTH, 32'(MAX_W));
    write_reg(REG_SCREEN_HEIGHT, 32'(MAX_H));
    cfg_valid <= 1'b0;
    send_item(mk_cursor(7'd0, 8'd0));
    send_item(mk_put(8'h00));
    send_item(mk_put(TOP_CODE));
    send_item(mk_put(8'h80));
    send_item(mk_put(8'hFF));
    send_item(mk_put(NEWLINE_CODE));
    send_item(mk_cursor(7'd127, 8'd0));
    send_item(mk_put(8'h55));
    send_item(mk_cursor(7'd126, 8'd255));
    send_item(mk_put(8'h41));
    send_item(mk_put(8'h41));
    send_item(mk_put(NEWLINE_CODE));
    odd = rand_fields();
    odd.operation = OP_UNUSED;
    send_item(odd);
    wait_drained();
    // partial cell clipped on both axes, then wrap
    apply_config(1'b1, 20, 40, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(mk_cursor(7'd2, 8'd2));
    send_item(mk_put(TOP_CODE));
    send_item(mk_put(8'h3C));
    send_item(mk_put(8'h2A));
    wait_drained();
    // zero-size screen: nothing writable, every cell wraps
    apply_config(1'b1, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(mk_put(8'h41));
    send_item(mk_put(8'h2A));
    wait_drained();
    apply_config(1'b1, MAX_W - 1, MAX_H - 1, $urandom, $urandom);
    send_item(mk_cursor(7'd127, 8'd47));
    send_item(mk_put(8'h55));
    wait_drained();
  endtask

  task automatic test_back_to_back();
    apply_config(1'b1, MAX_W, MAX_H, $urandom, $urandom);
    calm = 1'b1;
    repeat (30) send_item(rand_item());
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    repeat (5) begin
      pick_screen_setup();
      repeat (13) send_item(rand_item());
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_rows++;
      if (cell_rows_q.size() == 0) begin
        $display("%0t: expected no cell row, got %p", $time, out_data);
        errors++;
      end else begin
        want_row = cell_rows_q.pop_front();
        check_field("pixel_x", 32'(want_row.pixel_x), 32'(out_data.pixel_x));
        check_field("pixel_y", 32'(want_row.pixel_y), 32'(out_data.pixel_y));
        check_field("write_mask", 32'(want_row.write_mask), 32'(out_data.write_mask));
        check_field("fore_mask", 32'(want_row.fore_mask), 32'(out_data.fore_mask));
        check_field("fore_color", want_row.fore_color, out_data.fore_color);
        check_field("back_color", want_row.back_color, out_data.back_color);
        check_field("last", 32'(want_row.last), 32'(out_data.last));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_console();
    test_glyph_loading();
    test_drawing_edges();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d input transactions and %0d register writes", n_items, n_cfg);
    $display("%0d cells drawn, %0d cell rows checked, %0d errors", n_cells, n_rows, errors);
    if (errors == 0 && cell_rows_q.size() == 0) begin
      $display("text_console_glyph_renderer_core: match");
    end else begin
      if (cell_rows_q.size() != 0)
        $display("%0t: expected 0 pending cell rows, got %0d", $time, cell_rows_q.size());
      $display("text_console_glyph_renderer_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("text_console_glyph_renderer_core: mismatch");
    $finish;
  end

endmodule

// ===== text_console_glyph_renderer_core.f =====
design/tcgr_pkg.sv
design/text_console_glyph_renderer_core.sv
design/tcgr_checker.sv
dv/tb.sv
